@@ sv/stab_pkg.sv @@
// Shared types and codes for the sorted table engine.
`default_nettype none

package stab_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam int KEY_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_OUT_W = 7;
  localparam int CAP_W = 7;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [POS_W-1:0]        position;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic signed [KEY_W-1:0] smallest;
    logic signed [KEY_W-1:0] largest;
  } out_item_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/sorted_table_engine.sv @@
// Sorted table engine: row of compare-and-shift cells holding keys in ascending order.
// An accepted item's outcome is registered in stage 1, then in the output register
// once that is free. Throughput: one item per cycle while out_ready stays high; the
// cells update on accept; position encode and min/max select run as stage 1 advances.
// Reset (rst_n low, synchronous): table empty, capacity 64, no item pending.
// Cell contents are not reset; only slots below the count affect a result.
`default_nettype none

module sorted_table_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire stab_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output stab_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic [stab_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > stab_pkg::CAP_W) ? CNT_W : stab_pkg::CAP_W;
  localparam int KW = stab_pkg::KEY_W;

  logic [stab_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       s1_vld_r, s1_vld_nxt;
  logic [1:0]                 s1_status_r;
  logic [1:0]                 s1_status_nxt;
  logic [DEPTH-1:0]           s1_hot_r;
  logic [DEPTH-1:0]           s1_hot_nxt;
  logic                       out_vld_r, out_vld_nxt;
  stab_pkg::out_item_t        out_item_r;
  stab_pkg::out_item_t        out_item_nxt;

  logic signed [KW-1:0] vals [DEPTH];
  logic [DEPTH-1:0]     occ, le, eq, ins_hot, eq_hot, last_hot;
  logic                 acc, out_free, s1_adv, full, found;
  logic                 is_ins, is_del, is_srch;
  stab_pkg::cell_ctl_t  ctl;

  assign out_free = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;
  assign acc      = in_valid && in_ready;

  assign is_ins  = in_item.operation == stab_pkg::OP_INSERT;
  assign is_del  = in_item.operation == stab_pkg::OP_DELETE;
  assign is_srch = in_item.operation == stab_pkg::OP_SEARCH;

  assign full  = (LIM_W'(count_r) >= LIM_W'(cap_r)) || (count_r == CNT_W'(DEPTH));
  assign found = |eq;

  assign ctl.ins = acc && is_ins && !full;
  assign ctl.del = acc && is_del && found;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                 lo_le_w;
      logic signed [KW-1:0] lo_val_w;
      logic signed [KW-1:0] hi_val_w;

      assign occ[gi] = CNT_W'(gi) < count_r;

      if (gi == 0) begin : g_lo_end
        assign lo_le_w  = 1'b1;
        assign lo_val_w = in_item.key;
        assign ins_hot[gi] = !le[gi];
        assign eq_hot[gi]  = eq[gi];
      end else begin : g_lo_mid
        assign lo_le_w  = le[gi-1];
        assign lo_val_w = vals[gi-1];
        assign ins_hot[gi] = !le[gi] && le[gi-1];
        assign eq_hot[gi]  = eq[gi] && !eq[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_hi_end
        assign hi_val_w     = vals[gi];
        assign last_hot[gi] = occ[gi];
      end else begin : g_hi_mid
        assign hi_val_w     = vals[gi+1];
        assign last_hot[gi] = occ[gi] && !occ[gi+1];
      end

      stab_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .key    (in_item.key),
        .occ    (occ[gi]),
        .lo_le  (lo_le_w),
        .lo_val (lo_val_w),
        .hi_val (hi_val_w),
        .val    (vals[gi]),
        .le     (le[gi]),
        .eq     (eq[gi])
      );
    end
  endgenerate

  // outcome of the accepted item, captured alongside the cell update
  always_comb begin
    s1_status_nxt = stab_pkg::ST_MISSING;
    s1_hot_nxt    = '0;
    count_nxt     = count_r;
    if (is_ins) begin
      if (full) begin
        s1_status_nxt = stab_pkg::ST_FULL;
      end else begin
        s1_status_nxt = stab_pkg::ST_DONE;
        s1_hot_nxt    = ins_hot;
        count_nxt     = count_r + CNT_W'(1);
      end
    end else if (is_del || is_srch) begin
      if (found) begin
        s1_status_nxt = stab_pkg::ST_DONE;
        s1_hot_nxt    = eq_hot;
        if (is_del) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
    end
  end

  // result stage: encode the one-hot slot, pick first and last stored values
  always_comb begin
    out_item_nxt.status      = s1_status_r;
    out_item_nxt.position    = '0;
    out_item_nxt.entry_count = stab_pkg::CNT_OUT_W'(count_r);
    out_item_nxt.smallest    = (count_r != '0) ? vals[0] : '0;
    out_item_nxt.largest     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (s1_hot_r[i]) begin
        out_item_nxt.position = out_item_nxt.position | stab_pkg::POS_W'(i);
      end
      if (last_hot[i]) begin
        out_item_nxt.largest = out_item_nxt.largest | vals[i];
      end
    end
  end

  assign s1_vld_nxt  = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= stab_pkg::CAP_W'(64);
      count_r   <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (acc) begin
        count_r <= count_nxt;
      end
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status_r <= s1_status_nxt;
      s1_hot_r    <= s1_hot_nxt;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ sv/stab_cell.sv @@
// One slot of the sorted row: compares against the broadcast key, shifts up or down.
`default_nettype none

module stab_cell (
  input  wire logic                              clk,
  input  wire stab_pkg::cell_ctl_t               ctl,
  input  wire logic signed [stab_pkg::KEY_W-1:0] key,
  input  wire logic                              occ,
  input  wire logic                              lo_le,
  input  wire logic signed [stab_pkg::KEY_W-1:0] lo_val,
  input  wire logic signed [stab_pkg::KEY_W-1:0] hi_val,
  output logic signed [stab_pkg::KEY_W-1:0]      val,
  output logic                                   le,
  output logic                                   eq
);

  logic signed [stab_pkg::KEY_W-1:0] val_r;
  logic signed [stab_pkg::KEY_W-1:0] val_nxt;
  logic                              lt;

  assign val = val_r;
  assign le  = occ && (val_r <= key);
  assign lt  = occ && (val_r <  key);
  assign eq  = occ && (val_r == key);

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && !le) begin
      // first cell above the keys <= new key takes the key, the rest shift up
      val_nxt = lo_le ? key : lo_val;
    end else if (ctl.del && !lt) begin
      val_nxt = hi_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the sorted table engine: directed rows, then random phases.
`timescale 1ns / 1ps

module tb;
  import stab_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_SHOWN = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef struct {
    bit                      cap_write;
    logic [CAP_W-1:0]        cap;
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
    bit                      typed;
    out_item_t               want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  sorted_table_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the table and the capacity register
  logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
  int table_count;
  int cap_reg;

  out_item_t expected_q [$];
  out_item_t oldest_expected;
  dir_row_t  directed_rows [$];

  int send_gap_pct;
  int recv_stall_pct;
  int fail_count;
  int items_sent;
  int results_seen;
  int refused_inserts;
  int deletes_done;
  int searches_hit;
  int peak_count;

  int phase_cap [PHASES] = '{64, 127, 0, 1, 5, 16, 64, 3, 40, 127};
  int phase_ins [PHASES] = '{75, 70, 50, 50, 55, 60, 25, 50, 65, 40};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Applies one operation to the shadow table and returns the result it should produce.
  function automatic out_item_t apply_table_op(input logic [1:0] op,
                                               input logic signed [KEY_W-1:0] key);
    out_item_t r;
    int limit;
    int slot;
    int i;
    r = '0;
    r.status = ST_MISSING;
    limit = (cap_reg < TABLE_DEPTH) ? cap_reg : TABLE_DEPTH;
    case (op)
      OP_INSERT: begin
        if (table_count >= limit) begin
          r.status = ST_FULL;
        end else begin
          // new key lands after any equal keys
          slot = table_count;
          while (slot > 0 && key < table_keys[slot-1]) begin
            table_keys[slot] = table_keys[slot-1];
            slot--;
          end
          table_keys[slot] = key;
          table_count++;
          r.status = ST_DONE;
          r.position = slot[POS_W-1:0];
        end
      end
      OP_DELETE, OP_SEARCH: begin
        slot = 0;
        while (slot < table_count && table_keys[slot] != key) slot++;
        if (slot < table_count) begin
          r.status = ST_DONE;
          r.position = slot[POS_W-1:0];
          if (op == OP_DELETE) begin
            for (i = slot; i + 1 < table_count; i++) table_keys[i] = table_keys[i+1];
            table_count--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = table_count[CNT_OUT_W-1:0];
    if (table_count > 0) begin
      r.smallest = table_keys[0];
      r.largest = table_keys[table_count-1];
    end
    return r;
  endfunction

  // Mostly keys from a small set (small values, extremes, stored keys) so duplicates, hits and deletes are common.
  function automatic logic signed [KEY_W-1:0] pick_key(input bit want_stored);
    logic signed [KEY_W-1:0] k;
    int r;
    r = $urandom_range(0, 99);
    if (want_stored && table_count > 0 && r < 60) begin
      k = table_keys[$urandom_range(0, table_count - 1)];
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        k = int'($urandom_range(0, 16)) - 8;
      end else if (r < 65) begin
        case ($urandom_range(0, 5))
          0: k = KEY_MAX;
          1: k = KEY_MIN;
          2: k = KEY_MAX - 1;
          3: k = KEY_MIN + 1;
          4: k = '0;
          default: k = -1;
        endcase
      end else begin
        k = $urandom;
      end
    end
    return k;
  endfunction

  function automatic void add_row(input bit cap_write, input logic [CAP_W-1:0] cap,
                                  input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                                  input bit typed, input logic [1:0] st,
                                  input logic [POS_W-1:0] pos,
                                  input logic [CNT_OUT_W-1:0] cnt,
                                  input logic signed [KEY_W-1:0] lo,
                                  input logic signed [KEY_W-1:0] hi);
    dir_row_t row;
    row.cap_write = cap_write;
    row.cap = cap;
    row.op = op;
    row.key = key;
    row.typed = typed;
    row.want.status = st;
    row.want.position = pos;
    row.want.entry_count = cnt;
    row.want.smallest = lo;
    row.want.largest = hi;
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                           input bit typed, input out_item_t want);
    in_item_t item;
    out_item_t predicted;
    item.operation = op;
    item.key = key;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    predicted = apply_table_op(op, key);
    expected_q.push_back(typed ? want : predicted);
    items_sent++;
    if (op == OP_INSERT && predicted.status == ST_FULL) refused_inserts++;
    if (op == OP_DELETE && predicted.status == ST_DONE) deletes_done++;
    if (op == OP_SEARCH && predicted.status == ST_DONE) searches_hit++;
    if (table_count > peak_count) peak_count = table_count;
  endtask

  // Hold off the sender until every outstanding result is back, plus pipeline slack.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_reg = cap;
  endtask

  always @(negedge clk) begin
    out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("tb: result with nothing expected: st=%0d pos=%0d cnt=%0d min=%0d max=%0d",
                   out_item.status, out_item.position, out_item.entry_count,
                   out_item.smallest, out_item.largest);
      end else begin
        oldest_expected = expected_q.pop_front();
        if (out_item.status !== oldest_expected.status ||
            out_item.position !== oldest_expected.position ||
            out_item.entry_count !== oldest_expected.entry_count ||
            out_item.smallest !== oldest_expected.smallest ||
            out_item.largest !== oldest_expected.largest) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("tb: mismatch on result %0d", results_seen);
            $display("  expected st=%0d pos=%0d cnt=%0d min=%0d max=%0d",
                     oldest_expected.status, oldest_expected.position,
                     oldest_expected.entry_count, oldest_expected.smallest,
                     oldest_expected.largest);
            $display("  actual   st=%0d pos=%0d cnt=%0d min=%0d max=%0d",
                     out_item.status, out_item.position, out_item.entry_count,
                     out_item.smallest, out_item.largest);
          end
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    out_item_t none;
    logic [1:0] op;
    logic signed [KEY_W-1:0] key;
    int p;
    int n;
    int r;
    int ins_pct;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    refused_inserts = 0;
    deletes_done = 0;
    searches_hit = 0;
    peak_count = 0;
    table_count = 0;
    cap_reg = 64;
    none = '0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // empty table, then extremes, duplicates, unused code and capacity corners
    add_row(1, 7'd64, OP_SEARCH, 0, 1, ST_MISSING, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, 5, 1, ST_MISSING, 0, 0, 0, 0);
    add_row(0, 0, OP_UNUSED, -1, 1, ST_MISSING, 0, 0, 0, 0);
    add_row(0, 0, OP_INSERT, KEY_MAX, 1, ST_DONE, 0, 1, KEY_MAX, KEY_MAX);
    add_row(0, 0, OP_INSERT, KEY_MIN, 1, ST_DONE, 0, 2, KEY_MIN, KEY_MAX);
    add_row(0, 0, OP_INSERT, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_INSERT, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_INSERT, -1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_SEARCH, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_SEARCH, KEY_MAX, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_SEARCH, 12345, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_UNUSED, KEY_MAX, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, KEY_MAX, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, KEY_MIN, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, -1, 1, ST_DONE, 0, 0, 0, 0);
    add_row(1, 7'd0, OP_INSERT, 7, 1, ST_FULL, 0, 0, 0, 0);
    add_row(1, 7'd1, OP_INSERT, 7, 1, ST_DONE, 0, 1, 7, 7);
    add_row(0, 0, OP_INSERT, -7, 1, ST_FULL, 0, 1, 7, 7);
    add_row(1, 7'd127, OP_INSERT, -7, 1, ST_DONE, 0, 2, -7, 7);
    add_row(0, 0, OP_DELETE, 7, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_DELETE, -7, 1, ST_DONE, 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.cap_write) write_capacity(row.cap);
      send_item(row.op, row.key, row.typed, row.want);
    end

    // table contents carry across phases, so lowering capacity below the count is exercised
    for (p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p][CAP_W-1:0]);
      send_gap_pct = (p % 4 == 1) ? 63 : (p % 4 == 3) ? 33 : 0;
      recv_stall_pct = (p % 4 == 2) ? 63 : (p % 4 == 3) ? 33 : 0;
      ins_pct = phase_ins[p];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) op = OP_INSERT;
        else if (r < ins_pct + (100 - ins_pct) / 2) op = OP_DELETE;
        else if (r < 97) op = OP_SEARCH;
        else op = OP_UNUSED;
        key = pick_key(op == OP_DELETE || op == OP_SEARCH);
        send_item(op, key, 0, none);
      end
    end

    drain_results();
    fail_count += expected_q.size();

    $display("tb: %0d items sent, %0d results checked, peak occupancy %0d of %0d",
             items_sent, results_seen, peak_count, TABLE_DEPTH);
    $display("tb: %0d inserts refused, %0d deletes done, %0d searches hit",
             refused_inserts, deletes_done, searches_hit);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sorted_table_engine.f @@
sv/stab_pkg.sv
sv/stab_cell.sv
sv/sorted_table_engine.sv
verif/tb.sv
